/* sv/scsc_pkg.sv */
// shared types and constants for the set cover subset counter
`default_nettype none

package scsc_pkg;

	localparam int MASK_W   = 64;
	localparam int COUNT_W  = 17;
	localparam int ECOUNT_W = 7;

	localparam logic [ECOUNT_W-1:0] ECOUNT_RESET = 7'd64;
	localparam logic [COUNT_W-1:0]  TALLY_MAX    = '1;

	typedef struct packed {
		logic [MASK_W-1:0] set_mask;
		logic              is_last;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] cover_count;
		logic               overflow;
	} result_t;

	typedef struct packed {
		logic load;
		logic scan_init;
		logic scan_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic last_combo;
	} stat_t;

endpackage

`default_nettype wire

/* sv/set_cover_subset_counter.sv */
// top level of the set cover subset counter
// usage:
// sets come in on set_item, one per cycle with start high while busy is low.
// a set without is_last is stored and busy stays low.
// a set with is_last is stored, then every subcollection of the stored sets
// is checked, one per cycle, against the full mask of element_count low bits.
// the last item starts the subset scan through the set table (up to MAX_SETS
// stored sets) at one combination per cycle, followed by a flush state.
// busy is high from the accepting edge through the done cycle. done pulses
// for one cycle with result
// holding cover_count and the overflow flag; the receiver cannot stall, so
// the result must be taken in that cycle. sets beyond MAX_SETS are dropped
// and raise overflow. after done the table is empty for the next collection.
// element_count is written on the cfg channel (always ready); the user must write it only when idle, not enforced.
// reset clears the set count, overflow flag and tally and sets
// element_count to 64; table contents are not cleared.
`default_nettype none

module set_cover_subset_counter #(
	parameter int MAX_SETS     = 16,
	parameter int ELEMENT_BITS = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire scsc_pkg::item_t               set_item,
	output logic                               done,
	output scsc_pkg::result_t                  result,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [scsc_pkg::ECOUNT_W-1:0] cfg_data
);

	scsc_pkg::cmd_t  cmd;
	scsc_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	scsc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.is_last (set_item.is_last),
		.stat    (stat),
		.busy    (busy),
		.done    (done),
		.cmd     (cmd)
	);

	scsc_dp #(
		.MAX_SETS     (MAX_SETS),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.set_mask (set_item.set_mask),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.stat     (stat),
		.result   (result)
	);

endmodule

`default_nettype wire

/* sv/scsc_ctrl.sv */
// controller state machine for the set cover subset counter
`default_nettype none

module scsc_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          is_last,
	input  wire scsc_pkg::stat_t stat,
	output logic               busy,
	output logic               done,
	output scsc_pkg::cmd_t     cmd
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_FLUSH = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		busy          = 1'b1;
		done          = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					if (is_last) begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (stat.last_combo) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				done       = 1'b1;
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* sv/scsc_dp.sv */
// datapath: set table, subset scan, union compare and tally
`default_nettype none

module scsc_dp #(
	parameter int MAX_SETS     = 16,
	parameter int ELEMENT_BITS = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire scsc_pkg::cmd_t                  cmd,
	input  wire logic [scsc_pkg::MASK_W-1:0]     set_mask,
	input  wire logic                            cfg_we,
	input  wire logic [scsc_pkg::ECOUNT_W-1:0]   cfg_data,
	output scsc_pkg::stat_t                      stat,
	output scsc_pkg::result_t                    result
);

	localparam int LW = $clog2(MAX_SETS + 1);
	localparam int AW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int IW = MAX_SETS + 1;

	logic [ELEMENT_BITS-1:0]          table_q [MAX_SETS];
	logic [LW-1:0]                    loaded_q;
	logic                             overflow_q;
	logic [scsc_pkg::ECOUNT_W-1:0]    element_count_q;
	logic [IW-1:0]                    index_q;
	logic [ELEMENT_BITS-1:0]          union_s1;
	logic                             valid_s1;
	logic [scsc_pkg::COUNT_W-1:0]     tally_q;
	logic [ELEMENT_BITS-1:0]          union_d;
	logic [ELEMENT_BITS-1:0]          target;
	logic [IW-1:0]                    top;
	logic                             full;

	assign full = (loaded_q == LW'(MAX_SETS));
	assign top  = IW'(1) << loaded_q;
	assign stat.last_combo = ((index_q + IW'(1)) == top);

	always_comb begin
		union_d = '0;
		for (int j = 0; j < MAX_SETS; j++) begin
			union_d = union_d | (table_q[j] & {ELEMENT_BITS{index_q[j]}});
		end
	end

	always_comb begin
		for (int b = 0; b < ELEMENT_BITS; b++) begin
			target[b] = (element_count_q > scsc_pkg::ECOUNT_W'(b));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			table_q[loaded_q[AW-1:0]] <= set_mask[ELEMENT_BITS-1:0];
		end
		union_s1 <= union_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q        <= '0;
			overflow_q      <= 1'b0;
			element_count_q <= scsc_pkg::ECOUNT_RESET;
			index_q         <= '0;
			valid_s1        <= 1'b0;
			tally_q         <= '0;
		end else begin
			if (cfg_we) begin
				element_count_q <= cfg_data;
			end
			if (cmd.finish) begin
				loaded_q   <= '0;
				overflow_q <= 1'b0;
			end else if (cmd.load) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					loaded_q <= loaded_q + LW'(1);
				end
			end
			valid_s1 <= cmd.scan_step;
			if (cmd.scan_init) begin
				index_q <= '0;
			end else if (cmd.scan_step) begin
				index_q <= index_q + IW'(1);
			end
			if (cmd.scan_init) begin
				tally_q <= '0;
			end else if (valid_s1 && (union_s1 == target) &&
					(tally_q != scsc_pkg::TALLY_MAX)) begin
				tally_q <= tally_q + scsc_pkg::COUNT_W'(1);
			end
		end
	end

	assign result.cover_count = tally_q;
	assign result.overflow    = overflow_q;

endmodule

`default_nettype wire

/* sv/scsc_checker.sv */
// port checker for the set cover subset counter and its bind
`default_nettype none

module scsc_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            start,
	input wire logic            busy,
	input wire scsc_pkg::item_t set_item,
	input wire logic            done
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !set_item.is_last) |=> (!busy && !done))
		else $error("plain set did not finish in one cycle");

	a_last_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && set_item.is_last) |=> (busy && !done))
		else $error("last set did not start a scan");

	a_busy_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(done))
		else $error("busy dropped without a result");

endmodule

bind set_cover_subset_counter scsc_checker u_scsc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.set_item (set_item),
	.done     (done)
);

`default_nettype wire
